// File: rtl/fglad_pkg.sv
`timescale 1ns / 1ps
// fglad_pkg: types, constants and helper functions shared by the field grid blocks.
// No dependencies.
package fglad_pkg;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int IDX_W  = 5;
  localparam int ADDR_W = 3 * IDX_W;
  localparam int CELLS  = 1 << ADDR_W;
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 120;
  localparam int DVD_W  = 49;
  localparam int DVS_W  = 33;
  localparam int Q_W    = DVD_W + 1;
  localparam int ACC_W  = Q_W + 2;
  localparam int CNT_W  = 6;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_LOC  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;
  localparam logic [1:0] KIND_GRAD = 2'd3;

  localparam logic [2:0] CFG_START_X = 3'd0;
  localparam logic [2:0] CFG_START_Y = 3'd1;
  localparam logic [2:0] CFG_START_Z = 3'd2;
  localparam logic [2:0] CFG_BIN_X   = 3'd3;
  localparam logic [2:0] CFG_BIN_Y   = 3'd4;
  localparam logic [2:0] CFG_BIN_Z   = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [2:0][IDX_W-1:0]  idx;
    logic                   entry_valid;
    logic [2:0][31:0]       pos;
    logic [2:0][31:0]       fld;
    logic [1:0]             component;
  } item_t;

  typedef struct packed {
    logic             vld;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] fld;
  } mem_word_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } bk_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_LDIV, S_LWAIT, S_LRD, S_LRDW,
    S_QHI, S_QLO, S_QCHK, S_QDIV, S_QNEXT, S_OUT
  } bk_state_t;

  function automatic logic [IDX_W:0] grid_dim(input logic [1:0] axis);
    logic [IDX_W:0] d;
    unique case (axis)
      AXIS_X:  d = (IDX_W+1)'(GRID_X);
      AXIS_Y:  d = (IDX_W+1)'(GRID_Y);
      default: d = (IDX_W+1)'(GRID_Z);
    endcase
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [2:0][IDX_W-1:0] idx);
    return {idx[2], idx[1], idx[0]};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(signed'(32'sh7fffffff)))      r = 32'sh7fffffff;
    else if (v < ACC_W'(signed'(32'sh80000000))) r = 32'sh80000000;
    else                                          r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/field_grid_lookup_and_derivatives.sv
`timescale 1ns / 1ps
// field_grid_lookup_and_derivatives: top level of the 3D field grid store.
// Depends on fglad_pkg, fglad_front, fglad_back (which holds fglad_div).

// A 32x32x32 grid of field samples (valid mark, position in um, field in uT) with
// load, point locate, divergence and gradient commands; one result beat per input
// beat, in order. After reset the block runs a clearing pass over all 32768 grid
// memory entries (one entry a cycle) and accepts no command until it finishes;
// up to two input beats are queued meanwhile, and config writes are always taken.
// A locate needs one pass of the single shared bit-serial divider per axis and one
// read of the grid memory; a divergence or gradient query needs two reads of the
// grid memory per axis and at most one divider pass per axis.
// Derivatives are (dB * 65536) / dP in Q16.16 T/m, truncated toward zero, saturated.
module field_grid_lookup_and_derivatives (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  // index_x, index_y, index_z, entry_valid, pos_x, pos_y, pos_z,
  // field_x, field_y, field_z, component (low bit up)
  input  logic [215:0] in_tdata,
  input  logic [1:0]   in_tuser,   // kind
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_index_x, out_index_y, out_index_z, value_x, value_y, value_z, axis_mask
  output logic [119:0] out_tdata,
  output logic         out_tuser,  // found
  // config writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic                q_valid, q_pop;
  fglad_pkg::item_t    q_item;
  fglad_pkg::bk_stat_t stat;

  // front: beat intake and short command queue
  fglad_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: grid memory, divider and sequencer
  fglad_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .stat(stat)
  );

`ifndef SYNTHESIS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !q_pop) else $error("command taken during clearing pass");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (stat.idle && q_valid)) else $error("pop outside idle or on empty queue");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid) else $error("result beat repeated");
`endif

endmodule

// File: rtl/fglad_front.sv
`timescale 1ns / 1ps
// fglad_front: input beat intake and two-entry command queue.
// Depends on fglad_pkg.
module fglad_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fglad_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           q_valid,
  output fglad_pkg::item_t               q_item,
  input  logic                           q_pop
);

  fglad_pkg::item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  fglad_pkg::item_t in_item;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rp_r];

  always_comb begin
    in_item.kind        = in_tuser;
    in_item.idx[0]      = in_tdata[4:0];
    in_item.idx[1]      = in_tdata[9:5];
    in_item.idx[2]      = in_tdata[14:10];
    in_item.entry_valid = in_tdata[15];
    in_item.pos[0]      = in_tdata[47:16];
    in_item.pos[1]      = in_tdata[79:48];
    in_item.pos[2]      = in_tdata[111:80];
    in_item.fld[0]      = in_tdata[143:112];
    in_item.fld[1]      = in_tdata[175:144];
    in_item.fld[2]      = in_tdata[207:176];
    in_item.component   = in_tdata[209:208];
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      unique case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/fglad_div.sv
`timescale 1ns / 1ps
// fglad_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on fglad_pkg.
module fglad_div (
  input  logic                clk,
  input  logic                rst_n,
  input  fglad_pkg::div_req_t req,
  output fglad_pkg::div_rsp_t rsp
);

  logic [fglad_pkg::DVD_W-1:0] dvd_r;
  logic [fglad_pkg::DVS_W:0]   rem_r, sh, diff;
  logic [fglad_pkg::DVS_W-1:0] dvs_r;
  logic [fglad_pkg::CNT_W-1:0] cnt_r;
  logic                        busy_r, done_r, ge;

  assign sh   = {rem_r[fglad_pkg::DVS_W-1:0], dvd_r[fglad_pkg::DVD_W-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff : sh;
      dvd_r <= {dvd_r[fglad_pkg::DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fglad_pkg::CNT_W'(fglad_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/fglad_back.sv
`timescale 1ns / 1ps
// fglad_back: grid memory, config registers, command sequencer and result register.
// Depends on fglad_pkg and fglad_div.
module fglad_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            q_valid,
  input  fglad_pkg::item_t                q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fglad_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output fglad_pkg::bk_stat_t             stat
);

  fglad_pkg::mem_word_t mem [fglad_pkg::CELLS];
  fglad_pkg::mem_word_t rd_r, hi_r, wd;
  logic [fglad_pkg::ADDR_W-1:0] ra, wa, clr_r;
  logic we;

  fglad_pkg::bk_state_t state_r, state_nxt;
  fglad_pkg::item_t item_r;
  logic [1:0] axis_r;
  logic [2:0][31:0] start_r;
  logic [2:0][30:0] bin_r;

  fglad_pkg::div_req_t dreq;
  fglad_pkg::div_rsp_t drsp;

  logic [2:0][fglad_pkg::Q_W-1:0]   q_r;
  logic signed [fglad_pkg::ACC_W-1:0] acc_r;
  logic [2:0] mask_r, inb_r;
  logic [2:0][fglad_pkg::IDX_W-1:0] bin_idx_r;
  logic loc_hit_r, neg_r, out_valid_r, out_free;
  logic found_r;
  logic [2:0][fglad_pkg::IDX_W-1:0] oidx_r;
  logic [2:0][31:0] val_r;
  logic [2:0] omask_r;

  logic [fglad_pkg::IDX_W-1:0] cidx;
  logic [2:0][fglad_pkg::IDX_W-1:0] hi_idx, lo_idx;
  logic nb_ok, center_ok, def_ok;
  logic [1:0] comp;
  logic signed [32:0] dp, db, ln;
  logic [32:0] dp_mag, db_mag, ln_mag;
  logic signed [fglad_pkg::Q_W-1:0] qs;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {6'd0, omask_r, val_r[2], val_r[1], val_r[0],
                       oidx_r[2], oidx_r[1], oidx_r[0]};
  assign out_free   = !out_valid_r || out_tready;
  assign stat.clearing = (state_r == fglad_pkg::S_CLEAR);
  assign stat.idle     = (state_r == fglad_pkg::S_IDLE);

  fglad_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // neighbor addressing and difference terms
  always_comb begin
    cidx      = item_r.idx[axis_r];
    center_ok = ({1'b0, item_r.idx[0]} < fglad_pkg::grid_dim(fglad_pkg::AXIS_X)) &&
                ({1'b0, item_r.idx[1]} < fglad_pkg::grid_dim(fglad_pkg::AXIS_Y)) &&
                ({1'b0, item_r.idx[2]} < fglad_pkg::grid_dim(fglad_pkg::AXIS_Z));
    nb_ok     = center_ok && (cidx != '0) &&
                (({1'b0, cidx} + 1'b1) < fglad_pkg::grid_dim(axis_r));
    hi_idx    = item_r.idx;
    lo_idx    = item_r.idx;
    hi_idx[axis_r] = cidx + 1'b1;
    lo_idx[axis_r] = cidx - 1'b1;
    if (item_r.kind == fglad_pkg::KIND_DIV) comp = axis_r;
    else if (item_r.component == 2'd3)     comp = fglad_pkg::AXIS_Z;
    else                                   comp = item_r.component;
    dp     = 33'(signed'(hi_r.pos[axis_r])) - 33'(signed'(rd_r.pos[axis_r]));
    db     = 33'(signed'(hi_r.fld[comp]))   - 33'(signed'(rd_r.fld[comp]));
    dp_mag = dp[32] ? 33'(-dp) : dp;
    db_mag = db[32] ? 33'(-db) : db;
    def_ok = hi_r.vld && rd_r.vld && (dp != '0);
    ln     = 33'(signed'(item_r.pos[axis_r])) - 33'(signed'(start_r[axis_r]));
    ln_mag = ln[32] ? 33'(-ln) : ln;
    qs     = neg_r ? -signed'({1'b0, drsp.quot}) : signed'({1'b0, drsp.quot});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fglad_pkg::S_CLEAR:
        if (clr_r == fglad_pkg::ADDR_W'(fglad_pkg::CELLS - 1)) state_nxt = fglad_pkg::S_IDLE;
      fglad_pkg::S_IDLE:
        if (q_valid && out_free) begin
          unique case (q_item.kind)
            fglad_pkg::KIND_LOAD: state_nxt = fglad_pkg::S_LOAD;
            fglad_pkg::KIND_LOC:  state_nxt = fglad_pkg::S_LDIV;
            default:              state_nxt = fglad_pkg::S_QHI;
          endcase
        end
      fglad_pkg::S_LOAD:  state_nxt = fglad_pkg::S_OUT;
      fglad_pkg::S_LDIV:  state_nxt = fglad_pkg::S_LWAIT;
      fglad_pkg::S_LWAIT:
        if (drsp.done)
          state_nxt = (axis_r == fglad_pkg::AXIS_Z) ? fglad_pkg::S_LRD : fglad_pkg::S_LDIV;
      fglad_pkg::S_LRD:   state_nxt = fglad_pkg::S_LRDW;
      fglad_pkg::S_LRDW:  state_nxt = fglad_pkg::S_OUT;
      fglad_pkg::S_QHI:   state_nxt = nb_ok ? fglad_pkg::S_QLO : fglad_pkg::S_QNEXT;
      fglad_pkg::S_QLO:   state_nxt = fglad_pkg::S_QCHK;
      fglad_pkg::S_QCHK:  state_nxt = def_ok ? fglad_pkg::S_QDIV : fglad_pkg::S_QNEXT;
      fglad_pkg::S_QDIV:  if (drsp.done) state_nxt = fglad_pkg::S_QNEXT;
      fglad_pkg::S_QNEXT:
        state_nxt = (axis_r == fglad_pkg::AXIS_Z) ? fglad_pkg::S_OUT : fglad_pkg::S_QHI;
      fglad_pkg::S_OUT:   state_nxt = fglad_pkg::S_IDLE;
      default:            state_nxt = fglad_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = 1'b0;
    we    = 1'b0;
    wa    = clr_r;
    wd    = '0;
    ra    = fglad_pkg::cell_addr(bin_idx_r);
    dreq  = '0;
    unique case (state_r)
      fglad_pkg::S_CLEAR: we = 1'b1;
      fglad_pkg::S_IDLE:  q_pop = q_valid && out_free;
      fglad_pkg::S_LOAD: begin
        we = center_ok;
        wa = fglad_pkg::cell_addr(item_r.idx);
        wd.vld = item_r.entry_valid;
        wd.pos = item_r.pos;
        wd.fld = item_r.fld;
      end
      fglad_pkg::S_LDIV: begin
        dreq.start    = 1'b1;
        dreq.dividend = fglad_pkg::DVD_W'(ln_mag);
        dreq.divisor  = {2'b00, bin_r[axis_r]};
      end
      fglad_pkg::S_QHI: ra = fglad_pkg::cell_addr(hi_idx);
      fglad_pkg::S_QLO: ra = fglad_pkg::cell_addr(lo_idx);
      fglad_pkg::S_QCHK: begin
        dreq.start    = def_ok;
        dreq.dividend = {db_mag, 16'd0};
        dreq.divisor  = dp_mag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      fglad_pkg::S_IDLE: begin
        item_r <= q_item;
        q_r    <= '0;
        acc_r  <= '0;
      end
      fglad_pkg::S_LDIV: neg_r <= ln[32];
      fglad_pkg::S_LWAIT:
        if (drsp.done) begin
          inb_r[axis_r]     <= !neg_r &&
            (drsp.quot < fglad_pkg::DVD_W'(fglad_pkg::grid_dim(axis_r)));
          bin_idx_r[axis_r] <= drsp.quot[fglad_pkg::IDX_W-1:0];
        end
      fglad_pkg::S_LRDW: loc_hit_r <= (&inb_r) && rd_r.vld;
      fglad_pkg::S_QLO:  hi_r <= rd_r;
      fglad_pkg::S_QCHK: neg_r <= db[32] ^ dp[32];
      fglad_pkg::S_QDIV:
        if (drsp.done) begin
          q_r[axis_r] <= qs;
          acc_r <= acc_r + fglad_pkg::ACC_W'(qs);
        end
      fglad_pkg::S_OUT: begin
        found_r <= 1'b0;
        oidx_r  <= '0;
        val_r   <= '0;
        omask_r <= '0;
        unique case (item_r.kind)
          fglad_pkg::KIND_LOAD: found_r <= center_ok;
          fglad_pkg::KIND_LOC: begin
            found_r <= loc_hit_r;
            if (loc_hit_r) oidx_r <= bin_idx_r;
          end
          fglad_pkg::KIND_DIV: begin
            found_r <= (mask_r == 3'b111);
            omask_r <= mask_r;
            if (mask_r == 3'b111) val_r[0] <= fglad_pkg::sat32(acc_r);
          end
          default: begin
            omask_r  <= mask_r;
            val_r[0] <= fglad_pkg::sat32(fglad_pkg::ACC_W'(signed'(q_r[0])));
            val_r[1] <= fglad_pkg::sat32(fglad_pkg::ACC_W'(signed'(q_r[1])));
            val_r[2] <= fglad_pkg::sat32(fglad_pkg::ACC_W'(signed'(q_r[2])));
          end
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fglad_pkg::S_CLEAR;
      clr_r       <= '0;
      axis_r      <= fglad_pkg::AXIS_X;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      bin_r       <= {3{31'd1}};
    end else begin
      state_r <= state_nxt;
      if (state_r == fglad_pkg::S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == fglad_pkg::S_IDLE) begin
        axis_r <= fglad_pkg::AXIS_X;
        mask_r <= '0;
      end
      if ((state_r == fglad_pkg::S_LWAIT && drsp.done && axis_r != fglad_pkg::AXIS_Z) ||
          (state_r == fglad_pkg::S_QNEXT && axis_r != fglad_pkg::AXIS_Z))
        axis_r <= axis_r + 2'd1;
      if (state_r == fglad_pkg::S_QDIV && drsp.done) mask_r[axis_r] <= 1'b1;
      if (state_r == fglad_pkg::S_OUT) out_valid_r <= 1'b1;
      else if (out_tready)             out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          fglad_pkg::CFG_START_X: start_r[0] <= cfg_data;
          fglad_pkg::CFG_START_Y: start_r[1] <= cfg_data;
          fglad_pkg::CFG_START_Z: start_r[2] <= cfg_data;
          fglad_pkg::CFG_BIN_X: bin_r[0] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
          fglad_pkg::CFG_BIN_Y: bin_r[1] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
          fglad_pkg::CFG_BIN_Z: bin_r[2] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for field_grid_lookup_and_derivatives.
// Depends on fglad_pkg and the block's RTL; needs no files or arguments.
module tb_top;
  import fglad_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    int                 ix, iy, iz;
    bit                 ev;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] fx, fy, fz;
    logic [1:0]         comp;
  } probe_t;

  typedef struct {
    bit                 found;
    logic [4:0]         ox, oy, oz;
    logic signed [31:0] vx, vy, vz;
    logic [2:0]         mask;
  } reply_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [215:0] in_tdata;   // index_x, index_y, index_z, entry_valid, pos_x/y/z, field_x/y/z,
                            // component (low bit up)
  logic [1:0]   in_tuser;   // kind
  logic         out_tvalid, out_tready;
  logic [119:0] out_tdata;  // out_index_x/y/z, value_x/y/z, axis_mask (low bit up)
  logic         out_tuser;  // found
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  field_grid_lookup_and_derivatives dut (.*);

  // grid mirror and register copy
  bit                 g_vld [CELLS];
  logic signed [31:0] g_pos [3][CELLS];
  logic signed [31:0] g_fld [3][CELLS];
  longint             m_start [3];
  longint             m_bin   [3];

  probe_t pending_probes[$];
  reply_t expected_replies[$];
  probe_t cur_probe;
  int     send_gap, recv_gap;
  bit     no_gaps, recv_hold;
  int     n_errors, n_checked;
  int     n_kind [4];
  int     n_found, n_full_mask;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch #%0d at %0t: %s got %0d expected %0d", n_checked, $time, what, got, want);
    n_errors++;
  endtask

  function automatic int addr_of(input int x, input int y, input int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_div(input longint n, input longint b);
    longint q;
    q = n / b;
    if (n % b != 0 && n < 0) q--;
    return q;
  endfunction

  // one-axis central difference; 0 when the axis is undefined
  function automatic bit central_diff(input int x, input int y, input int z, input int axis,
                                      input int comp, output longint q);
    int hi, lo;
    int dx, dy, dz;
    longint dp, db;
    q = 0;
    dx = axis == 0; dy = axis == 1; dz = axis == 2;
    if (!in_grid(x + dx, y + dy, z + dz) || !in_grid(x - dx, y - dy, z - dz)) return 0;
    hi = addr_of(x + dx, y + dy, z + dz);
    lo = addr_of(x - dx, y - dy, z - dz);
    if (!g_vld[hi] || !g_vld[lo]) return 0;
    dp = longint'(g_pos[axis][hi]) - longint'(g_pos[axis][lo]);
    if (dp == 0) return 0;
    db = longint'(g_fld[comp][hi]) - longint'(g_fld[comp][lo]);
    q = (db * 65536) / dp;
    return 1;
  endfunction

  function automatic reply_t predict_reply(input probe_t p);
    reply_t r;
    longint b [3];
    longint sum, q;
    int a, c, comp;
    r = '{default: 0};
    comp = (p.comp > 2) ? 2 : p.comp;
    case (p.kind)
      KIND_LOAD: begin
        c = addr_of(p.ix, p.iy, p.iz);
        g_vld[c] = p.ev;
        g_pos[0][c] = p.px; g_pos[1][c] = p.py; g_pos[2][c] = p.pz;
        g_fld[0][c] = p.fx; g_fld[1][c] = p.fy; g_fld[2][c] = p.fz;
        r.found = 1;
      end
      KIND_LOC: begin
        b[0] = floor_div(longint'(p.px) - m_start[0], m_bin[0]);
        b[1] = floor_div(longint'(p.py) - m_start[1], m_bin[1]);
        b[2] = floor_div(longint'(p.pz) - m_start[2], m_bin[2]);
        if (b[0] >= 0 && b[0] < GRID_X && b[1] >= 0 && b[1] < GRID_Y && b[2] >= 0 &&
            b[2] < GRID_Z && g_vld[addr_of(int'(b[0]), int'(b[1]), int'(b[2]))]) begin
          r.found = 1;
          r.ox = b[0][4:0]; r.oy = b[1][4:0]; r.oz = b[2][4:0];
        end
      end
      KIND_DIV: begin
        sum = 0;
        for (a = 0; a < 3; a++)
          if (central_diff(p.ix, p.iy, p.iz, a, a, q)) begin
            sum += q;
            r.mask[a] = 1;
          end
        if (r.mask == 3'b111) begin
          r.found = 1;
          r.vx = sat_q(sum);
        end
      end
      default: begin
        if (central_diff(p.ix, p.iy, p.iz, 0, comp, q)) begin r.vx = sat_q(q); r.mask[0] = 1; end
        if (central_diff(p.ix, p.iy, p.iz, 1, comp, q)) begin r.vy = sat_q(q); r.mask[1] = 1; end
        if (central_diff(p.ix, p.iy, p.iz, 2, comp, q)) begin r.vz = sat_q(q); r.mask[2] = 1; end
      end
    endcase
    return r;
  endfunction

  function automatic logic [215:0] pack_probe(input probe_t p);
    return {6'd0, p.comp, p.fz, p.fy, p.fx, p.pz, p.py, p.px, p.ev,
            p.iz[4:0], p.iy[4:0], p.ix[4:0]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one beat at a time from pending_probes; predicts on acceptance
  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 0;
      send_gap = 0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_replies = {expected_replies, predict_reply(cur_probe)};
        n_kind[cur_probe.kind]++;
        nxt_valid = 0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_probes.size() > 0) begin
          cur_probe = pending_probes.pop_front();
          in_tdata <= pack_probe(cur_probe);
          in_tuser <= cur_probe.kind;
          nxt_valid = 1;
          send_gap = pick_gap();
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin
    reply_t w;
    if (!rst_n) begin
      out_tready <= 0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          w = expected_replies.pop_front();
          if (out_tuser != w.found) report_mismatch("found", out_tuser, w.found);
          if (out_tdata[4:0] != w.ox) report_mismatch("index_x", out_tdata[4:0], w.ox);
          if (out_tdata[9:5] != w.oy) report_mismatch("index_y", out_tdata[9:5], w.oy);
          if (out_tdata[14:10] != w.oz) report_mismatch("index_z", out_tdata[14:10], w.oz);
          if ($signed(out_tdata[46:15]) != w.vx)
            report_mismatch("value_x", $signed(out_tdata[46:15]), w.vx);
          if ($signed(out_tdata[78:47]) != w.vy)
            report_mismatch("value_y", $signed(out_tdata[78:47]), w.vy);
          if ($signed(out_tdata[110:79]) != w.vz)
            report_mismatch("value_z", $signed(out_tdata[110:79]), w.vz);
          if (out_tdata[113:111] != w.mask)
            report_mismatch("axis_mask", out_tdata[113:111], w.mask);
          n_found += w.found;
          n_full_mask += (w.mask == 3'b111);
        end
      end
      if (recv_hold) out_tready <= 0;
      else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    longint b;
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 0;
    b = val[30:0];
    if (b == 0) b = 1;
    case (idx)
      CFG_START_X: m_start[0] = longint'($signed(val));
      CFG_START_Y: m_start[1] = longint'($signed(val));
      CFG_START_Z: m_start[2] = longint'($signed(val));
      CFG_BIN_X:   m_bin[0] = b;
      CFG_BIN_Y:   m_bin[1] = b;
      default:     m_bin[2] = b;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] sx, sy, sz, bx, by, bz);
    write_reg(CFG_START_X, sx); write_reg(CFG_START_Y, sy); write_reg(CFG_START_Z, sz);
    write_reg(CFG_BIN_X, bx);   write_reg(CFG_BIN_Y, by);   write_reg(CFG_BIN_Z, bz);
  endtask

  function automatic probe_t mk(input logic [1:0] k, input int x, y, z, input bit ev,
                                input longint px, py, pz, fx, fy, fz, input int comp);
    probe_t p;
    p.kind = k; p.ix = x; p.iy = y; p.iz = z; p.ev = ev;
    p.px = px[31:0]; p.py = py[31:0]; p.pz = pz[31:0];
    p.fx = fx[31:0]; p.fy = fy[31:0]; p.fz = fz[31:0];
    p.comp = comp[1:0];
    return p;
  endfunction

  function automatic longint rnd32();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rnd_field();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 4000)) - 2000;
    if (r < 8) return rnd32();
    return r == 8 ? 64'sd2147483647 : -64'sd2147483648;
  endfunction

  // neighbour positions near 1000 um per cell, sometimes coincident
  function automatic longint rnd_pos(input int idx);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 5000;
    if (r == 1) return rnd32();
    if (r == 2) return idx;
    return idx * 1000 + $signed($urandom_range(0, 200)) - 100;
  endfunction

  // random item, mostly in a 4x4x4 region at (bx,by,bz)
  function automatic probe_t rnd_probe(input int bx, by, bz);
    probe_t p;
    int x, y, z, r, c;
    longint pt [3];
    x = bx + $urandom_range(0, 3); y = by + $urandom_range(0, 3); z = bz + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, 31); y = $urandom_range(0, 31); z = $urandom_range(0, 31);
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      p = mk(KIND_LOAD, x, y, z, $urandom_range(0, 7) != 0, rnd_pos(x), rnd_pos(y), rnd_pos(z),
             rnd_field(), rnd_field(), rnd_field(), $urandom_range(0, 3));
    end else if (r < 60) begin
      for (c = 0; c < 3; c++)
        pt[c] = m_start[c] + m_bin[c] * (c == 0 ? x : c == 1 ? y : z) +
                longint'($urandom()) % m_bin[c];
      if ($urandom_range(0, 4) == 0) begin
        pt[0] = rnd32(); pt[1] = rnd32(); pt[2] = rnd32();
      end
      p = mk(KIND_LOC, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 1), pt[0], pt[1], pt[2], rnd32(), rnd32(), rnd32(),
             $urandom_range(0, 3));
    end else begin
      p = mk(r < 80 ? KIND_DIV : KIND_GRAD, x, y, z, $urandom_range(0, 1), rnd32(), rnd32(),
             rnd32(), rnd32(), rnd32(), rnd32(), $urandom_range(0, 3));
    end
    return p;
  endfunction

  task automatic queue_probe(input probe_t p);
    pending_probes = {pending_probes, p};
  endtask

  // sampled mid-cycle so the driver's edge updates have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_probes.size() > 0 || in_tvalid || expected_replies.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  // receiver hold-off: long stall mid-run while the sender keeps offering
  initial begin
    recv_hold = 0;
    wait (n_checked >= 150);
    @(posedge clk);
    recv_hold = 1;
    repeat (4000) @(posedge clk);
    recv_hold = 0;
  end

  // stimulus and end of run
  initial begin
    int ph, i, bx, by, bz;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0; out_tready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    no_gaps = 0; n_errors = 0; n_checked = 0; n_found = 0; n_full_mask = 0;
    n_kind = '{default: 0};
    m_start = '{0, 0, 0};
    m_bin = '{1, 1, 1};
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: cross around (1,1,1) with unit bin size, uneven neighbour spacing, extreme fields
    set_grid(0, 0, 0, 1, 1, 1);
    queue_probe(mk(KIND_LOAD, 2, 1, 1, 1, 2, 1, 1, 2147483647, 5, 0, 0));
    queue_probe(mk(KIND_LOAD, 0, 1, 1, 1, 1, 1, 1, -2147483648, 0, 0, 0));
    queue_probe(mk(KIND_LOAD, 1, 2, 1, 1, 1, 3, 1, 0, -2147483648, 7, 0));
    queue_probe(mk(KIND_LOAD, 1, 0, 1, 1, 1, 0, 1, 0, 2147483647, 0, 0));
    queue_probe(mk(KIND_LOAD, 1, 1, 2, 1, 1, 1, 7, -1, 0, 1000, 3));
    queue_probe(mk(KIND_LOAD, 1, 1, 0, 1, 1, 1, -5, 1, 0, -1000, 3));
    queue_probe(mk(KIND_DIV, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_probe(mk(KIND_GRAD, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_probe(mk(KIND_GRAD, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1));
    queue_probe(mk(KIND_GRAD, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 3));
    // centre not loaded but cross complete; locate that empty cell misses
    queue_probe(mk(KIND_LOC, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
    queue_probe(mk(KIND_LOC, 0, 0, 0, 0, 2, 1, 1, 0, 0, 0, 0));
    queue_probe(mk(KIND_LOC, 0, 0, 0, 0, -1, 1, 1, 0, 0, 0, 0));
    // equal neighbour x positions: x axis undefined
    queue_probe(mk(KIND_LOAD, 0, 1, 1, 1, 2, 1, 1, 0, 0, 0, 0));
    queue_probe(mk(KIND_DIV, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // invalid neighbour; grid corners
    queue_probe(mk(KIND_LOAD, 1, 0, 1, 0, 1, 0, 1, 0, 0, 0, 0));
    queue_probe(mk(KIND_GRAD, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 2));
    queue_probe(mk(KIND_LOAD, 31, 31, 31, 1, -1, -1, -1, -1, -1, -1, 3));
    queue_probe(mk(KIND_LOC, 31, 31, 31, 1, 31, 31, 31, -1, -1, -1, 3));
    queue_probe(mk(KIND_DIV, 31, 31, 31, 1, -1, -1, -1, -1, -1, -1, 3));
    queue_probe(mk(KIND_GRAD, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_grid(-1000, -500, 0, 1000, 1000, 1000);
        1: set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: set_grid(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
        default: set_grid($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000,
                          $urandom_range(0, 20000) - 10000, $urandom_range(1, 3000),
                          $urandom_range(1, 3000), $urandom_range(1, 3000));
      endcase
      no_gaps = (ph == 3);
      for (i = 0; i < 165; i++) begin
        if (i % 40 == 0) begin
          bx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 28);
          by = $urandom_range(0, 1) ? 28 : $urandom_range(0, 28);
          bz = $urandom_range(0, 28);
        end
        queue_probe(rnd_probe(bx, by, bz));
      end
      drain();
    end

    $display("ran %0d loads, %0d locates, %0d divergence and %0d gradient beats",
             n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    $display("%0d results checked, %0d found, %0d with all three axes defined",
             n_checked, n_found, n_full_mask);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
